FILE: rtl/core/hce_pkg.sv
package hce_pkg;

    // Defaults for the top-level parameters
    localparam int SYMBOLS_DEF       = 256;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int MAX_CODE_BITS_DEF = 64;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int VAL_W   = 8;
    localparam int CNT_W   = 32;
    localparam int NB_W    = 4;
    localparam int KIND_W  = 2;
    localparam int CLEN_W  = 7;
    localparam int CBITS_W = 64;
    localparam int ERR_W   = 2;
    localparam int MAX_NB  = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_BUILD  = 3'd2;
    localparam logic [OP_W-1:0] OP_ENCODE = 3'd3;
    localparam logic [OP_W-1:0] OP_DECODE = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYM  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LONG   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd3;

    // Classified command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             in_range;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic [NB_W-1:0]  nbits;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VAL_W-1:0]   symbol;
        logic [CLEN_W-1:0]  code_length;
        logic [CBITS_W-1:0] code_bits;
        logic [ERR_W-1:0]   error_code;
        logic               last;
    } t_res;

    function automatic t_res mk_res(
        input logic [KIND_W-1:0]  kind,
        input logic [VAL_W-1:0]   symbol,
        input logic [CLEN_W-1:0]  code_length,
        input logic [CBITS_W-1:0] code_bits,
        input logic [ERR_W-1:0]   error_code,
        input logic               last
    );
        t_res r;
        r.kind        = kind;
        r.symbol      = symbol;
        r.code_length = code_length;
        r.code_bits   = code_bits;
        r.error_code  = error_code;
        r.last        = last;
        return r;
    endfunction

endpackage

FILE: rtl/core/hce_if.sv
// Input channel
interface hce_in_if;
    logic                        valid;
    logic                        ready;
    logic [hce_pkg::OP_W-1:0]    operation;
    logic [hce_pkg::VAL_W-1:0]   value;
    logic [hce_pkg::CNT_W-1:0]   count;
    logic [hce_pkg::NB_W-1:0]    bit_count;

    modport source(output valid, operation, value, count, bit_count, input ready);
    modport sink(input valid, operation, value, count, bit_count, output ready);
endinterface

// Result channel
interface hce_out_if;
    logic                        valid;
    logic                        ready;
    logic [hce_pkg::KIND_W-1:0]  kind;
    logic [hce_pkg::VAL_W-1:0]   symbol;
    logic [hce_pkg::CLEN_W-1:0]  code_length;
    logic [hce_pkg::CBITS_W-1:0] code_bits;
    logic [hce_pkg::ERR_W-1:0]   error_code;
    logic                        last;

    modport source(output valid, kind, symbol, code_length, code_bits, error_code, last,
                   input ready);
    modport sink(input valid, kind, symbol, code_length, code_bits, error_code, last,
                 output ready);
endinterface

FILE: rtl/core/hce_ram.sv
module hce_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                      i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                      o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/hce_front.sv
module hce_front #(
    parameter int SYMBOLS    = hce_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS = hce_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hce_in_if.sink        i_in,
    output hce_pkg::t_cmd o_cmd,
    output logic          o_cmd_vld,
    input  logic          i_pop
);
    localparam logic [hce_pkg::CNT_W:0] MAXC =
        (33'd1 << COUNT_BITS) - 33'd1;

    hce_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    hce_pkg::t_cmd n_cmd;
    logic          push;

    // Classify: range check, count saturation, bit count clamp
    always_comb begin
        n_cmd.op       = i_in.operation;
        n_cmd.value    = i_in.value;
        n_cmd.in_range = ({1'b0, i_in.value} < 9'(SYMBOLS));
        n_cmd.count    = ({1'b0, i_in.count} > MAXC) ? MAXC[hce_pkg::CNT_W-1:0]
                                                      : i_in.count;
        n_cmd.nbits    = (i_in.bit_count > hce_pkg::NB_W'(hce_pkg::MAX_NB))
                         ? hce_pkg::NB_W'(hce_pkg::MAX_NB) : i_in.bit_count;
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid & i_in.ready;

    // Two-entry queue towards the back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    assign o_cmd     = r_q[r_rp];
    assign o_cmd_vld = (r_cnt != 2'd0);
endmodule

FILE: rtl/core/hce_back.sv
module hce_back #(
    parameter int SYMBOLS       = hce_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS    = hce_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_BITS = hce_pkg::MAX_CODE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hce_pkg::t_cmd i_cmd,
    input  logic          i_cmd_vld,
    output logic          o_pop,
    hce_out_if.source     o_out
);
    localparam int NODES = 2 * SYMBOLS - 1;
    localparam int SW    = $clog2(SYMBOLS);
    localparam int NW    = $clog2(NODES);
    localparam int IW    = $clog2(SYMBOLS + 1);
    localparam int WW    = COUNT_BITS + SW;
    localparam int DW    = SW + 1;
    localparam int LKW   = 2 * NW + 1 + hce_pkg::VAL_W;
    localparam int PW    = MAX_CODE_BITS;
    localparam int LW    = hce_pkg::CLEN_W;
    localparam int CW    = PW + LW;
    localparam int CBW   = hce_pkg::CBITS_W;
    localparam logic [31:0] MAXB = 32'(MAX_CODE_BITS);
    localparam logic [COUNT_BITS-1:0] MAXW = '1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CNT   = 4'd1;
    localparam logic [3:0] S_ENC   = 4'd2;
    localparam logic [3:0] S_SORT  = 4'd3;
    localparam logic [3:0] S_MRD   = 4'd4;
    localparam logic [3:0] S_MPK   = 4'd5;
    localparam logic [3:0] S_CROOT = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CEV   = 4'd8;
    localparam logic [3:0] S_CWR   = 4'd9;
    localparam logic [3:0] S_DRD   = 4'd10;
    localparam logic [3:0] S_DCK   = 4'd11;
    localparam logic [3:0] S_DFIN  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    typedef struct packed {
        logic [3:0]          state;
        logic [3:0]          ret;
        hce_pkg::t_res       res;
        hce_pkg::t_cmd       cmd;
        logic                tree_ready;
        logic [NW-1:0]       root;
        logic [NW-1:0]       dec;
        logic [NW-1:0]       nn;
        logic [NW-1:0]       nc;
        logic [NW-1:0]       lh;
        logic [NW-1:0]       ih;
        logic [IW-1:0]       idx;
        logic                have_prev;
        logic [COUNT_BITS-1:0] pw;
        logic [7:0]          ps;
        logic                found;
        logic [COUNT_BITS-1:0] mw;
        logic [7:0]          ms;
        logic                second;
        logic [NW-1:0]       a;
        logic [WW-1:0]       wa;
        logic [NW-1:0]       k;
        logic                too_long;
        logic [NW-1:0]       cr;
        logic [DW-1:0]       cd;
        logic [PW-1:0]       cp;
        logic [2:0]          bitn;
        logic                stepped;
        logic                pend_v;
        logic [7:0]          pend_s;
        logic                o_vld;
        hce_pkg::t_res       o;
    } t_bst;

    t_bst r_s, n_s;
    logic [SYMBOLS-1:0] r_hvld;

    // Memory ports
    logic                  h_we;
    logic [SW-1:0]         h_wa, h_ra;
    logic [COUNT_BITS-1:0] h_wd, h_rd;
    logic                  lw_we;
    logic [SW-1:0]         lw_wa, lw_ra;
    logic [COUNT_BITS-1:0] lw_wd, lw_rd;
    logic                  iw_we;
    logic [SW-1:0]         iw_wa, iw_ra;
    logic [WW-1:0]         iw_wd, iw_rd;
    logic                  lk_we;
    logic [NW-1:0]         lk_wa, lk_ra;
    logic [LKW-1:0]        lk_wd, lk_rd;
    logic                  dp_we;
    logic [NW-1:0]         dp_wa, dp_ra;
    logic [DW-1:0]         dp_wd, dp_rd;
    logic                  pt_we;
    logic [NW-1:0]         pt_wa, pt_ra;
    logic [PW-1:0]         pt_wd, pt_rd;
    logic                  cd_we;
    logic [SW-1:0]         cd_wa, cd_ra;
    logic [CW-1:0]         cd_wd, cd_rd;

    // Working signals
    logic                  can_emit;
    logic [COUNT_BITS-1:0] hw;
    logic [7:0]            s_sym;
    logic [SW-1:0]         s_hidx;
    logic [COUNT_BITS-1:0] s_w;
    logic                  s_cand, s_take, f_found;
    logic [COUNT_BITS-1:0] f_w;
    logic [7:0]            f_s;
    logic                  m_lav, m_iav, m_leaf;
    logic [WW-1:0]         m_lw, m_w;
    logic [NW-1:0]         m_node;
    logic [NW-1:0]         lk_left, lk_right;
    logic                  lk_leaf;
    logic [7:0]            lk_sym;
    logic [DW-1:0]         c_d1;
    logic [PW-1:0]         c_bit;
    logic                  adv;
    logic                  last_bit;
    logic [3:0]            nxt;

    hce_ram #(.W(COUNT_BITS), .D(SYMBOLS)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd));
    hce_ram #(.W(COUNT_BITS), .D(SYMBOLS)) u_leafw (
        .i_clk(i_clk), .i_we(lw_we), .i_waddr(lw_wa), .i_wdata(lw_wd),
        .i_raddr(lw_ra), .o_rdata(lw_rd));
    hce_ram #(.W(WW), .D(SYMBOLS)) u_intw (
        .i_clk(i_clk), .i_we(iw_we), .i_waddr(iw_wa), .i_wdata(iw_wd),
        .i_raddr(iw_ra), .o_rdata(iw_rd));
    hce_ram #(.W(LKW), .D(NODES)) u_links (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_wa), .i_wdata(lk_wd),
        .i_raddr(lk_ra), .o_rdata(lk_rd));
    hce_ram #(.W(DW), .D(NODES)) u_depth (
        .i_clk(i_clk), .i_we(dp_we), .i_waddr(dp_wa), .i_wdata(dp_wd),
        .i_raddr(dp_ra), .o_rdata(dp_rd));
    hce_ram #(.W(PW), .D(NODES)) u_path (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_wa), .i_wdata(pt_wd),
        .i_raddr(pt_ra), .o_rdata(pt_rd));
    hce_ram #(.W(CW), .D(SYMBOLS)) u_code (
        .i_clk(i_clk), .i_we(cd_we), .i_waddr(cd_wa), .i_wdata(cd_wd),
        .i_raddr(cd_ra), .o_rdata(cd_rd));

    // Link word fields
    assign lk_left  = lk_rd[NW-1:0];
    assign lk_right = lk_rd[2*NW-1:NW];
    assign lk_leaf  = lk_rd[2*NW];
    assign lk_sym   = lk_rd[LKW-1:2*NW+1];

    // Histogram entry, zero until written since reset
    assign hw = r_hvld[SW'(r_s.cmd.value)] ? h_rd : '0;

    // Sort scan: next leaf is the lightest (weight, symbol) above the last one
    assign s_sym   = 8'(r_s.idx - IW'(1));
    assign s_hidx  = SW'(r_s.idx - IW'(1));
    assign s_w     = r_hvld[s_hidx] ? h_rd : '0;
    assign s_cand  = (r_s.idx != '0) && (s_w != '0) &&
                     (!r_s.have_prev || (s_w > r_s.pw) ||
                      ((s_w == r_s.pw) && (s_sym > r_s.ps)));
    assign s_take  = s_cand && (!r_s.found || (s_w < r_s.mw));
    assign f_found = r_s.found | s_take;
    assign f_w     = s_take ? s_w : r_s.mw;
    assign f_s     = s_take ? s_sym : r_s.ms;

    // Merge pick: leaf queue wins ties against the internal queue
    assign m_lav  = (r_s.lh < r_s.nn);
    assign m_iav  = (r_s.ih < r_s.nc);
    assign m_lw   = WW'(lw_rd);
    assign m_leaf = m_lav && (!m_iav || (m_lw <= iw_rd));
    assign m_node = m_leaf ? r_s.lh : r_s.ih;
    assign m_w    = m_leaf ? m_lw : iw_rd;

    // Code fill: child depth and right-branch path bit
    assign c_d1 = dp_rd + DW'(1);
    always_comb begin
        for (int j = 0; j < PW; j++) begin
            c_bit[j] = (32'(dp_rd) == 32'(j));
        end
    end

    assign last_bit = ({1'b0, r_s.bitn} + 4'd1 == r_s.cmd.nbits);
    assign nxt      = last_bit ? S_DFIN : S_DRD;
    assign can_emit = !r_s.o_vld || o_out.ready;

    // Sequencer
    always_comb begin
        n_s   = r_s;
        o_pop = 1'b0;
        adv   = 1'b0;
        h_we  = 1'b0; h_wa = SW'(r_s.cmd.value); h_wd = '0;
        h_ra  = SW'(r_s.cmd.value);
        lw_we = 1'b0; lw_wa = SW'(r_s.nn); lw_wd = f_w; lw_ra = SW'(r_s.lh);
        iw_we = 1'b0; iw_wa = SW'(r_s.nc - r_s.nn); iw_wd = r_s.wa + m_w;
        iw_ra = SW'(r_s.ih - r_s.nn);
        lk_we = 1'b0; lk_wa = r_s.nn; lk_wd = '0; lk_ra = r_s.k;
        dp_we = 1'b0; dp_wa = r_s.cr; dp_wd = r_s.cd; dp_ra = r_s.k;
        pt_we = 1'b0; pt_wa = r_s.cr; pt_wd = r_s.cp; pt_ra = r_s.k;
        cd_we = 1'b0; cd_wa = SW'(lk_sym); cd_wd = {LW'(dp_rd), pt_rd};
        cd_ra = SW'(r_s.cmd.value);

        if (r_s.o_vld && o_out.ready) begin
            n_s.o_vld = 1'b0;
        end

        unique case (r_s.state)
            S_IDLE: begin
                h_ra  = SW'(i_cmd.value);
                cd_ra = SW'(i_cmd.value);
                if (i_cmd_vld) begin
                    o_pop   = 1'b1;
                    n_s.cmd = i_cmd;
                    n_s.ret = S_IDLE;
                    unique case (i_cmd.op)
                        hce_pkg::OP_COUNT: begin
                            n_s.tree_ready = 1'b0;
                            if (i_cmd.in_range) begin
                                n_s.state = S_CNT;
                            end else begin
                                n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ACK, '0, '0, '0,
                                                            hce_pkg::ERR_NONE, 1'b1);
                                n_s.state = S_OUT;
                            end
                        end
                        hce_pkg::OP_SET: begin
                            n_s.tree_ready = 1'b0;
                            h_we = i_cmd.in_range;
                            h_wa = SW'(i_cmd.value);
                            h_wd = COUNT_BITS'(i_cmd.count);
                            n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ACK, '0, '0, '0,
                                                        hce_pkg::ERR_NONE, 1'b1);
                            n_s.state = S_OUT;
                        end
                        hce_pkg::OP_BUILD: begin
                            n_s.tree_ready = 1'b0;
                            n_s.nn         = '0;
                            n_s.have_prev  = 1'b0;
                            n_s.idx        = '0;
                            n_s.found      = 1'b0;
                            n_s.state      = S_SORT;
                        end
                        hce_pkg::OP_ENCODE: begin
                            n_s.state = S_ENC;
                        end
                        hce_pkg::OP_DECODE: begin
                            n_s.bitn    = '0;
                            n_s.stepped = 1'b0;
                            n_s.pend_v  = 1'b0;
                            if (!r_s.tree_ready) begin
                                n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ERR, '0, '0, '0,
                                                            hce_pkg::ERR_ABSENT, 1'b1);
                                n_s.state = S_OUT;
                            end else if (i_cmd.nbits == '0) begin
                                n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ACK, '0, '0, '0,
                                                            hce_pkg::ERR_NONE, 1'b1);
                                n_s.state = S_OUT;
                            end else begin
                                n_s.state = S_DRD;
                            end
                        end
                        default: begin
                            n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ERR, '0, '0, '0,
                                                        hce_pkg::ERR_NONE, 1'b1);
                            n_s.state = S_OUT;
                        end
                    endcase
                end
            end

            // Saturating increment
            S_CNT: begin
                h_we      = 1'b1;
                h_wd      = (hw == MAXW) ? hw : hw + COUNT_BITS'(1);
                n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ACK, '0, '0, '0,
                                            hce_pkg::ERR_NONE, 1'b1);
                n_s.ret   = S_IDLE;
                n_s.state = S_OUT;
            end

            S_ENC: begin
                if (!r_s.tree_ready || !r_s.cmd.in_range || (hw == '0)) begin
                    n_s.res = hce_pkg::mk_res(hce_pkg::KIND_ERR, r_s.cmd.value, '0, '0,
                                              hce_pkg::ERR_ABSENT, 1'b1);
                end else begin
                    n_s.res = hce_pkg::mk_res(hce_pkg::KIND_CODE, r_s.cmd.value,
                                              cd_rd[CW-1:PW], CBW'(cd_rd[PW-1:0]),
                                              hce_pkg::ERR_NONE, 1'b1);
                end
                n_s.ret   = S_IDLE;
                n_s.state = S_OUT;
            end

            // One histogram entry per cycle; one leaf per pass
            S_SORT: begin
                h_ra      = SW'(r_s.idx);
                n_s.found = f_found;
                n_s.mw    = f_w;
                n_s.ms    = f_s;
                if (r_s.idx == IW'(SYMBOLS)) begin
                    if (f_found) begin
                        lw_we         = 1'b1;
                        lk_we         = 1'b1;
                        lk_wd         = {f_s, 1'b1, {(2*NW){1'b0}}};
                        n_s.nn        = r_s.nn + NW'(1);
                        n_s.pw        = f_w;
                        n_s.ps        = f_s;
                        n_s.have_prev = 1'b1;
                        n_s.found     = 1'b0;
                        n_s.idx       = '0;
                    end else if (r_s.nn == '0) begin
                        n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_ERR, '0, '0, '0,
                                                    hce_pkg::ERR_EMPTY, 1'b1);
                        n_s.ret   = S_IDLE;
                        n_s.state = S_OUT;
                    end else begin
                        n_s.lh     = '0;
                        n_s.ih     = r_s.nn;
                        n_s.nc     = r_s.nn;
                        n_s.second = 1'b0;
                        n_s.root   = '0;
                        n_s.state  = (r_s.nn == NW'(1)) ? S_CROOT : S_MRD;
                    end
                end else begin
                    n_s.idx = r_s.idx + IW'(1);
                end
            end

            S_MRD: begin
                n_s.state = S_MPK;
            end

            // Take the lighter queue head; second pick closes a merge
            S_MPK: begin
                if (m_leaf) begin
                    n_s.lh = r_s.lh + NW'(1);
                end else begin
                    n_s.ih = r_s.ih + NW'(1);
                end
                if (!r_s.second) begin
                    n_s.a      = m_node;
                    n_s.wa     = m_w;
                    n_s.second = 1'b1;
                    n_s.state  = S_MRD;
                end else begin
                    iw_we      = 1'b1;
                    lk_we      = 1'b1;
                    lk_wa      = r_s.nc;
                    lk_wd      = {8'd0, 1'b0, m_node, r_s.a};
                    n_s.nc     = r_s.nc + NW'(1);
                    n_s.second = 1'b0;
                    if (r_s.nc - r_s.nn + NW'(1) == r_s.nn - NW'(1)) begin
                        n_s.root  = r_s.nc;
                        n_s.state = S_CROOT;
                    end else begin
                        n_s.state = S_MRD;
                    end
                end
            end

            S_CROOT: begin
                dp_we        = 1'b1;
                dp_wa        = r_s.root;
                dp_wd        = '0;
                pt_we        = 1'b1;
                pt_wa        = r_s.root;
                pt_wd        = '0;
                n_s.k        = r_s.nc - NW'(1);
                n_s.too_long = 1'b0;
                n_s.state    = S_CRD;
            end

            S_CRD: begin
                n_s.state = S_CEV;
            end

            // Nodes top-down: children always carry lower indices
            S_CEV: begin
                if (!lk_leaf) begin
                    dp_we     = 1'b1;
                    dp_wa     = lk_left;
                    dp_wd     = c_d1;
                    pt_we     = 1'b1;
                    pt_wa     = lk_left;
                    pt_wd     = pt_rd;
                    n_s.cr    = lk_right;
                    n_s.cd    = c_d1;
                    n_s.cp    = pt_rd | c_bit;
                    n_s.state = S_CWR;
                end else begin
                    if (32'(dp_rd) > MAXB) begin
                        n_s.too_long = 1'b1;
                    end else begin
                        cd_we = 1'b1;
                    end
                    adv = 1'b1;
                end
            end

            S_CWR: begin
                dp_we = 1'b1;
                pt_we = 1'b1;
                adv   = 1'b1;
            end

            S_DRD: begin
                lk_ra     = r_s.dec;
                n_s.state = S_DCK;
            end

            // One compressed bit: step once, then test for a leaf
            S_DCK: begin
                if (!lk_leaf && !r_s.stepped) begin
                    n_s.dec     = r_s.cmd.value[r_s.bitn] ? lk_right : lk_left;
                    n_s.stepped = 1'b1;
                    n_s.state   = S_DRD;
                end else begin
                    n_s.stepped = 1'b0;
                    n_s.bitn    = r_s.bitn + 3'd1;
                    n_s.state   = nxt;
                    if (lk_leaf) begin
                        n_s.dec    = r_s.root;
                        n_s.pend_v = 1'b1;
                        n_s.pend_s = lk_sym;
                        if (r_s.pend_v) begin
                            n_s.res   = hce_pkg::mk_res(hce_pkg::KIND_SYM, r_s.pend_s, '0,
                                                        '0, hce_pkg::ERR_NONE, 1'b0);
                            n_s.ret   = nxt;
                            n_s.state = S_OUT;
                        end
                    end
                end
            end

            S_DFIN: begin
                if (r_s.pend_v) begin
                    n_s.res = hce_pkg::mk_res(hce_pkg::KIND_SYM, r_s.pend_s, '0, '0,
                                              hce_pkg::ERR_NONE, 1'b1);
                end else begin
                    n_s.res = hce_pkg::mk_res(hce_pkg::KIND_ACK, '0, '0, '0,
                                              hce_pkg::ERR_NONE, 1'b1);
                end
                n_s.ret   = S_IDLE;
                n_s.state = S_OUT;
            end

            // Hand the staged result to the output register
            S_OUT: begin
                if (can_emit) begin
                    n_s.o_vld = 1'b1;
                    n_s.o     = r_s.res;
                    n_s.state = r_s.ret;
                end
            end

            default: begin
                n_s.state = S_IDLE;
            end
        endcase

        // Next node of the code fill, or end of build
        if (adv) begin
            if (r_s.k == '0) begin
                n_s.ret   = S_IDLE;
                n_s.state = S_OUT;
                if (n_s.too_long) begin
                    n_s.res = hce_pkg::mk_res(hce_pkg::KIND_ERR, '0, '0, '0,
                                              hce_pkg::ERR_LONG, 1'b1);
                end else begin
                    n_s.tree_ready = 1'b1;
                    n_s.dec        = r_s.root;
                    n_s.res        = hce_pkg::mk_res(hce_pkg::KIND_ACK, '0, '0, '0,
                                                     hce_pkg::ERR_NONE, 1'b1);
                end
            end else begin
                n_s.k     = r_s.k - NW'(1);
                n_s.state = S_CRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.state      <= S_IDLE;
            r_s.tree_ready <= 1'b0;
            r_s.o_vld      <= 1'b0;
            r_s.root       <= '0;
            r_s.dec        <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    // Histogram entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= '0;
        end else if (h_we) begin
            r_hvld[h_wa] <= 1'b1;
        end
    end

    assign o_out.valid       = r_s.o_vld;
    assign o_out.kind        = r_s.o.kind;
    assign o_out.symbol      = r_s.o.symbol;
    assign o_out.code_length = r_s.o.code_length;
    assign o_out.code_bits   = r_s.o.code_bits;
    assign o_out.error_code  = r_s.o.error_code;
    assign o_out.last        = r_s.o.last;
endmodule

FILE: rtl/core/huffman_codec_engine.sv
// Decode reads the link memory through its single read port, stepping at most once per
// valid bit, and emits each decoded symbol through the output register.
// Build: one sort scan over the histogram memory per leaf plus a final one, then the
// merges and the code fill node by node. One command is in work at a time;
// a two-entry queue takes further commands while a result waits in the output register.
// Reset clears control state; the histogram reads as zero through per-entry valid bits.
module huffman_codec_engine #(
    parameter int SYMBOLS       = hce_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS    = hce_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_BITS = hce_pkg::MAX_CODE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hce_in_if.sink    i_in_ch,
    hce_out_if.source o_out_ch
);
    hce_pkg::t_cmd cmd;
    logic          cmd_vld;
    logic          pop;

    hce_front #(
        .SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in_ch),
        .o_cmd(cmd), .o_cmd_vld(cmd_vld), .i_pop(pop)
    );

    hce_back #(
        .SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS), .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cmd_vld(cmd_vld),
        .o_pop(pop), .o_out(o_out_ch)
    );
endmodule
